// File: rtl/eap_tlv_pkg.sv
// Package for the EAP-TLV result parser: outcome codes, register indexes,
// header field positions and widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eap_tlv_pkg;

    // Sticky outcome of a message
    typedef enum logic [1:0] {
        OUT_CONTINUE = 2'd0,
        OUT_SUCCESS  = 2'd1,
        OUT_FAILURE  = 2'd2
    } outcome_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_REQUEST_SUCCESS = 2'd0,
        REG_RESULT_TYPE     = 2'd1,
        REG_SUCCESS_STATUS  = 2'd2,
        REG_FAILURE_STATUS  = 2'd3
    } cfg_index_t;

    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned CfgDataWidth  = 16;
    localparam int unsigned TypeWidth     = 14;
    localparam int unsigned LenWidth      = 16;
    localparam int unsigned StatusWidth   = 16;

    // Header byte 0: bit 7 is the mandatory flag, bits 5..0 the type high bits
    localparam int unsigned MandBit       = 7;
    localparam int unsigned TypeHighBits  = 6;

    // Header bytes held before the fourth one completes the header
    localparam logic [1:0]  HeaderHeld    = 2'd3;
    // Status is the first two value bytes of a Result TLV
    localparam logic [1:0]  StatusBytes   = 2'd2;

endpackage : eap_tlv_pkg

`default_nettype wire

// File: rtl/eap_tlv_if.sv
// Channel interfaces of the EAP-TLV result parser: payload byte words,
// result words and configuration writes. Depends on eap_tlv_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface eap_tlv_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    output ready);
endinterface : eap_tlv_item_if

interface eap_tlv_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] outcome;
    logic       done_res;
    logic       success;

    modport source (output valid, output outcome, output done_res, output success,
                    input ready);
    modport sink   (input valid, input outcome, input done_res, input success,
                    output ready);
endinterface : eap_tlv_result_if

interface eap_tlv_cfg_if
    import eap_tlv_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CfgIndexWidth-1:0] index;
    logic [CfgDataWidth-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : eap_tlv_cfg_if

`default_nettype wire

// File: rtl/eap_tlv_result_parser.sv
// EAP-TLV result parser. Takes the TLV payload one byte word per cycle,
// tracks the TLV framing and the status of the last Result TLV, and on the
// word marked last emits one result word with the sticky outcome.
//
// Throughput is one word per clock. A word is captured in an input register;
// from there the framing/status update and the outcome decision run as one
// short combinational step into the state registers and, for a last word, the
// result register. The input stage stalls only when it holds a last word and
// the result register still holds a word the sink has not taken. Configuration
// writes are always accepted (ready tied high) and take effect on the next
// cycle; they must be issued only while the block holds no word in flight.
// Depends on eap_tlv_pkg and the interfaces in eap_tlv_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module eap_tlv_result_parser
    import eap_tlv_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    eap_tlv_item_if.sink      item,
    eap_tlv_result_if.source  result,
    eap_tlv_cfg_if.sink       cfg
);

    // ---------------- configuration registers ----------------
    logic                   request_success_reg;
    logic [TypeWidth-1:0]   result_type_reg;
    logic [StatusWidth-1:0] success_status_reg;
    logic [StatusWidth-1:0] failure_status_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_success_reg <= 1'b0;
            result_type_reg     <= TypeWidth'(3);
            success_status_reg  <= StatusWidth'(1);
            failure_status_reg  <= StatusWidth'(2);
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                REG_REQUEST_SUCCESS: request_success_reg <= cfg.data[0];
                REG_RESULT_TYPE:     result_type_reg     <= cfg.data[TypeWidth-1:0];
                REG_SUCCESS_STATUS:  success_status_reg  <= cfg.data[StatusWidth-1:0];
                REG_FAILURE_STATUS:  failure_status_reg  <= cfg.data[StatusWidth-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_has_reg;
    logic       in_last_reg;

    logic out_valid_reg;
    logic out_free;     // result register can take a word this cycle
    logic stage_go;     // held word may be consumed this cycle
    logic stage_fire;   // held word is consumed this cycle

    assign out_free   = !out_valid_reg || result.ready;
    assign stage_go   = !in_last_reg || out_free;
    assign stage_fire = in_valid_reg && stage_go;
    assign item.ready = !in_valid_reg || stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_byte_reg <= item.data_byte;
            in_has_reg  <= item.has_byte;
            in_last_reg <= item.last;
        end
    end

    // ---------------- parser state ----------------
    logic [1:0]             header_count_reg,  header_count_next;
    logic [23:0]            header_hold_reg,   header_hold_next;
    logic [LenWidth-1:0]    value_left_reg,    value_left_next;
    logic                   in_value_reg,      in_value_next;
    logic                   cur_result_reg,    cur_result_next;
    logic [1:0]             status_taken_reg,  status_taken_next;
    logic [StatusWidth-1:0] status_hold_reg,   status_hold_next;
    logic                   result_seen_reg,   result_seen_next;
    logic                   too_short_reg,     too_short_next;
    logic                   msg_error_reg,     msg_error_next;
    outcome_t               sticky_reg,        sticky_next;

    logic [7:0]             hdr_b0;
    logic [TypeWidth-1:0]   hdr_type;
    logic [LenWidth-1:0]    hdr_len;
    outcome_t               decision;

    assign hdr_b0   = header_hold_reg[23:16];
    assign hdr_type = {hdr_b0[TypeHighBits-1:0], header_hold_reg[15:8]};
    assign hdr_len  = {header_hold_reg[7:0], in_byte_reg};

    always_comb
    begin
        header_count_next = header_count_reg;
        header_hold_next  = header_hold_reg;
        value_left_next   = value_left_reg;
        in_value_next     = in_value_reg;
        cur_result_next   = cur_result_reg;
        status_taken_next = status_taken_reg;
        status_hold_next  = status_hold_reg;
        result_seen_next  = result_seen_reg;
        too_short_next    = too_short_reg;
        msg_error_next    = msg_error_reg;
        sticky_next       = sticky_reg;
        decision          = OUT_FAILURE;

        // byte framing
        if (in_has_reg)
        begin
            if (in_value_reg)
            begin
                // status is the first two value bytes of a Result TLV
                if (cur_result_reg && (status_taken_reg < StatusBytes))
                begin
                    status_hold_next  = {status_hold_reg[7:0], in_byte_reg};
                    status_taken_next = status_taken_reg + 2'd1;
                end
                value_left_next = value_left_reg - LenWidth'(1);
                if (value_left_next == '0)
                begin
                    in_value_next = 1'b0;
                end
            end
            else if (header_count_reg < HeaderHeld)
            begin
                header_hold_next  = {header_hold_reg[15:0], in_byte_reg};
                header_count_next = header_count_reg + 2'd1;
            end
            else
            begin
                // fourth header byte completes the header
                header_count_next = '0;
                header_hold_next  = '0;
                if (hdr_type == result_type_reg)
                begin
                    cur_result_next   = 1'b1;
                    result_seen_next  = 1'b1;
                    too_short_next    = (hdr_len < LenWidth'(2));
                    status_taken_next = '0;
                    status_hold_next  = '0;
                end
                else
                begin
                    cur_result_next = 1'b0;
                    if (hdr_b0[MandBit])
                    begin
                        msg_error_next = 1'b1;
                    end
                end
                value_left_next = hdr_len;
                in_value_next   = (hdr_len != '0);
            end
        end

        // outcome, on the state after this byte
        priority if (msg_error_next || in_value_next || (header_count_next != '0))
        begin
            decision = OUT_FAILURE;
        end
        else if (!result_seen_next)
        begin
            decision = sticky_reg;
        end
        else if (too_short_next)
        begin
            decision = OUT_FAILURE;
        end
        else if (status_hold_next == success_status_reg)
        begin
            decision = request_success_reg ? OUT_SUCCESS : OUT_FAILURE;
        end
        else if (status_hold_next == failure_status_reg)
        begin
            decision = request_success_reg ? OUT_FAILURE : OUT_SUCCESS;
        end
        else
        begin
            decision = OUT_FAILURE;
        end

        // end of message: latch outcome, drop per-message state
        if (in_last_reg)
        begin
            sticky_next       = decision;
            header_count_next = '0;
            header_hold_next  = '0;
            value_left_next   = '0;
            in_value_next     = 1'b0;
            cur_result_next   = 1'b0;
            status_taken_next = '0;
            status_hold_next  = '0;
            result_seen_next  = 1'b0;
            too_short_next    = 1'b0;
            msg_error_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg <= '0;
            header_hold_reg  <= '0;
            value_left_reg   <= '0;
            in_value_reg     <= 1'b0;
            cur_result_reg   <= 1'b0;
            status_taken_reg <= '0;
            status_hold_reg  <= '0;
            result_seen_reg  <= 1'b0;
            too_short_reg    <= 1'b0;
            msg_error_reg    <= 1'b0;
            sticky_reg       <= OUT_CONTINUE;
        end
        else if (stage_fire)
        begin
            header_count_reg <= header_count_next;
            header_hold_reg  <= header_hold_next;
            value_left_reg   <= value_left_next;
            in_value_reg     <= in_value_next;
            cur_result_reg   <= cur_result_next;
            status_taken_reg <= status_taken_next;
            status_hold_reg  <= status_hold_next;
            result_seen_reg  <= result_seen_next;
            too_short_reg    <= too_short_next;
            msg_error_reg    <= msg_error_next;
            sticky_reg       <= sticky_next;
        end
    end

    // ---------------- result register ----------------
    outcome_t res_outcome_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && in_last_reg)
        begin
            res_outcome_reg <= decision;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.outcome  = res_outcome_reg;
    assign result.done_res = (res_outcome_reg != OUT_CONTINUE);
    assign result.success  = (res_outcome_reg == OUT_SUCCESS);

    // ---------------- assertions ----------------
    // never mid-header and inside a value at once
    a_hdr_vs_value: assert property (@(posedge clk) disable iff (!rst_n)
        (header_count_reg != '0) |-> !in_value_reg)
        else $error("header bytes held while inside a TLV value");

    // inside a value there is always a byte left
    a_value_left: assert property (@(posedge clk) disable iff (!rst_n)
        in_value_reg |-> (value_left_reg != '0))
        else $error("in_value set with no value bytes left");

    // status counter stops at two
    a_status_taken: assert property (@(posedge clk) disable iff (!rst_n)
        status_taken_reg <= StatusBytes)
        else $error("status byte counter overran");

    // a consumed last word clears the message and loads the result register
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && in_last_reg) |=> (out_valid_reg && !result_seen_reg
            && !in_value_reg && (header_count_reg == '0) && !msg_error_reg))
        else $error("message state not cleared after last word");

endmodule : eap_tlv_result_parser

`default_nettype wire

// File: tb/tlv_outcome_monitor.sv
// Outcome monitor for the EAP-TLV result parser: watches the byte, result and
// register channels, tracks TLV framing and predicts each outcome word.
// Depends on eap_tlv_pkg and the channel interfaces in eap_tlv_if.sv.
`timescale 1ns / 1ps

module tlv_outcome_monitor
    import eap_tlv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    eap_tlv_item_if     item,
    eap_tlv_result_if   result,
    eap_tlv_cfg_if      cfg,
    output int unsigned mismatches,
    output int unsigned pending,
    output int unsigned compared
);

    typedef struct packed {
        outcome_t outcome;
        logic     done_res;
        logic     success;
    } verdict_t;

    // register shadows
    logic        want_success;
    logic [13:0] result_type;
    logic [15:0] ok_status;
    logic [15:0] bad_status;

    // framing of the message in progress
    logic [1:0]  hdr_taken;
    logic [23:0] hdr_bytes;
    logic [15:0] value_remaining;
    logic        inside_value;
    logic        in_result_tlv;
    logic [1:0]  status_taken;
    logic [15:0] status_word;
    logic        result_found;
    logic        result_short;
    logic        mandatory_hit;
    outcome_t    sticky_outcome;

    verdict_t    expected_outcomes[$];
    int unsigned error_count;
    int unsigned seen_count;

    task automatic note_mismatch(input string field, input logic [1:0] got,
                                 input logic [1:0] want);
        error_count++;
        $display("MISMATCH %s: got %0d, expected %0d (outcome word %0d)",
                 field, got, want, seen_count);
    endtask

    task automatic clear_framing();
        hdr_taken       = '0;
        hdr_bytes       = '0;
        value_remaining = '0;
        inside_value    = 1'b0;
        in_result_tlv   = 1'b0;
        status_taken    = '0;
        status_word     = '0;
        result_found    = 1'b0;
        result_short    = 1'b0;
        mandatory_hit   = 1'b0;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        logic [15:0] tlv_len;
        logic [13:0] hdr_code;
        if (inside_value) begin
            if (in_result_tlv && status_taken < StatusBytes) begin
                status_word  = {status_word[7:0], b};
                status_taken = status_taken + 2'd1;
            end
            value_remaining = value_remaining - 16'd1;
            if (value_remaining == 16'd0)
                inside_value = 1'b0;
        end else if (hdr_taken < HeaderHeld) begin
            hdr_bytes = {hdr_bytes[15:0], b};
            hdr_taken = hdr_taken + 2'd1;
        end else begin
            // fourth header byte completes the TLV header
            tlv_len  = {hdr_bytes[7:0], b};
            hdr_code = {hdr_bytes[16 +: TypeHighBits], hdr_bytes[15:8]};
            if (hdr_code == result_type) begin
                in_result_tlv = 1'b1;
                result_found  = 1'b1;
                result_short  = tlv_len < 16'd2;
                status_taken  = '0;
                status_word   = '0;
            end else begin
                in_result_tlv = 1'b0;
                if (hdr_bytes[16 + MandBit])
                    mandatory_hit = 1'b1;
            end
            hdr_taken       = '0;
            hdr_bytes       = '0;
            value_remaining = tlv_len;
            inside_value    = tlv_len != 16'd0;
        end
    endtask

    function automatic outcome_t judge_outcome();
        if (mandatory_hit || inside_value || hdr_taken != 2'd0)
            return OUT_FAILURE;
        if (!result_found)
            return sticky_outcome;
        if (result_short)
            return OUT_FAILURE;
        // success code is tested first: matters when both codes are equal
        if (status_word == ok_status)
            return want_success ? OUT_SUCCESS : OUT_FAILURE;
        if (status_word == bad_status)
            return want_success ? OUT_FAILURE : OUT_SUCCESS;
        return OUT_FAILURE;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            want_success   = 1'b0;
            result_type    = 14'd3;
            ok_status      = 16'd1;
            bad_status     = 16'd2;
            sticky_outcome = OUT_CONTINUE;
            clear_framing();
            expected_outcomes.delete();
            error_count = 0;
            seen_count  = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_index_t'(cfg.index))
                    REG_REQUEST_SUCCESS: want_success = cfg.data[0];
                    REG_RESULT_TYPE:     result_type  = cfg.data[13:0];
                    REG_SUCCESS_STATUS:  ok_status    = cfg.data;
                    REG_FAILURE_STATUS:  bad_status   = cfg.data;
                    default: ;
                endcase
            end

            // results first: an outcome word can never answer a word taken this edge
            if (result.valid && result.ready)
            begin
                if (expected_outcomes.size() == 0)
                    note_mismatch("unexpected outcome word", result.outcome, 2'd0);
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (result.outcome !== want.outcome)
                        note_mismatch("outcome", result.outcome, want.outcome);
                    if (result.done_res !== want.done_res)
                        note_mismatch("done_res", {1'b0, result.done_res},
                                      {1'b0, want.done_res});
                    if (result.success !== want.success)
                        note_mismatch("success", {1'b0, result.success},
                                      {1'b0, want.success});
                    seen_count++;
                end
            end

            if (item.valid && item.ready)
            begin
                if (item.has_byte)
                    absorb_byte(item.data_byte);
                if (item.last)
                begin
                    sticky_outcome = judge_outcome();
                    clear_framing();
                    want.outcome  = sticky_outcome;
                    want.done_res = sticky_outcome != OUT_CONTINUE;
                    want.success  = sticky_outcome == OUT_SUCCESS;
                    expected_outcomes.push_back(want);
                end
            end
        end
        mismatches <= error_count;
        pending    <= expected_outcomes.size();
        compared   <= seen_count;
    end

endmodule : tlv_outcome_monitor

// File: tb/tb.sv
// Top of the EAP-TLV result parser testbench: clock, reset, payload and
// register stimulus, result-side flow control and the final verdict.
// Depends on eap_tlv_pkg, eap_tlv_if.sv, the parser and tlv_outcome_monitor.
`timescale 1ns / 1ps

module tb;
    import eap_tlv_pkg::*;

    localparam int unsigned ITEM_TARGET      = 800;   // random payload words
    localparam int unsigned PHASES           = 6;     // register settings in the random part
    localparam int unsigned LONG_HOLD_CYCLES = 80;    // result side held off this long once
    localparam int unsigned DRAIN_CYCLES     = 4;     // extra wait in settle() after all outcome words are back
    localparam int unsigned TIMEOUT_NS       = 3_000_000;

    // one payload word as offered on the byte channel
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       fin;
    } tlv_word_t;

    logic clk;
    logic rst_n;

    eap_tlv_item_if   item_if();
    eap_tlv_result_if res_if();
    eap_tlv_cfg_if    cfg_if();

    int unsigned mismatches;
    int unsigned pending;
    int unsigned compared;

    eap_tlv_result_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    tlv_outcome_monitor outcome_mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_if),
        .result     (res_if),
        .cfg        (cfg_if),
        .mismatches (mismatches),
        .pending    (pending),
        .compared   (compared)
    );

    // current register values, used only to steer message content toward
    // the Result TLV type and the two status codes
    logic [13:0] cur_type;
    logic [15:0] cur_ok;
    logic [15:0] cur_bad;

    tlv_word_t   msg_words[$];
    logic [7:0]  payload_bytes[$];
    bit          noise_on;
    bit          sender_gaps;
    bit          calm;          // no idling on either side
    bit          long_hold;     // asks the result side for one long hold-off
    int unsigned payload_words;
    int unsigned messages;
    int unsigned settings_used;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    // Result side: random ready bursts, plus one long hold-off on request.
    // The long hold lets the parser back up so that it stalls the byte channel.
    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    // Offer one word and hold it until taken. Valid stays high between
    // back-to-back words; it drops only for an idle burst or a drain.
    task automatic push_word(input tlv_word_t w);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        item_if.valid     <= 1'b1;
        item_if.data_byte <= w.data;
        item_if.has_byte  <= w.has;
        item_if.last      <= w.fin;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        if (w.has || w.fin)
            payload_words++;
    endtask

    task automatic send_message();
        sender_gaps = !calm && ($urandom_range(0, 2) != 0);
        foreach (msg_words[i])
            push_word(msg_words[i]);
        messages++;
    endtask

    // Stop offering and wait until every outcome word is back, then wait out the
    // drain time so no non-last word is still inside the parser.
    task automatic settle();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
    endtask

    // All four registers, written only with the parser idle.
    // Unused upper data bits carry random values; the parser ignores them.
    task automatic apply_setting(input logic req, input logic [13:0] typ,
                                 input logic [15:0] ok, input logic [15:0] bad);
        settle();
        write_reg(REG_REQUEST_SUCCESS, {15'($urandom), req});
        write_reg(REG_RESULT_TYPE, {2'($urandom), typ});
        write_reg(REG_SUCCESS_STATUS, ok);
        write_reg(REG_FAILURE_STATUS, bad);
        cfg_if.valid <= 1'b0;
        cur_type = typ;
        cur_ok   = ok;
        cur_bad  = bad;
        settings_used++;
    endtask

    // byte word, sometimes followed by an empty non-last word the parser skips
    task automatic queue_byte(input logic [7:0] b);
        msg_words.push_back('{data: b, has: 1'b1, fin: 1'b0});
        if (noise_on && $urandom_range(0, 5) == 0)
            msg_words.push_back('{data: 8'($urandom), has: 1'b0, fin: 1'b0});
    endtask

    // Mark the end of the message: on the final byte word, or on a separate
    // word with no byte (always so for an empty payload).
    task automatic seal_message(input bit tail_empty);
        while (msg_words.size() > 0 && !msg_words[msg_words.size()-1].has)
            void'(msg_words.pop_back());
        if (tail_empty || msg_words.size() == 0)
            msg_words.push_back('{data: 8'($urandom), has: 1'b0, fin: 1'b1});
        else
            msg_words[msg_words.size()-1].fin = 1'b1;
    endtask

    task automatic send_payload(input bit tail_empty);
        msg_words.delete();
        foreach (payload_bytes[i])
            msg_words.push_back('{data: payload_bytes[i], has: 1'b1, fin: 1'b0});
        seal_message(tail_empty);
        send_message();
    endtask

    // One TLV with header and value. Result TLVs mostly carry one of the two
    // status codes; other TLVs set the mandatory bit now and then.
    task automatic queue_tlv();
        logic        is_res;
        logic        mand;
        logic [13:0] t;
        logic [15:0] tlv_len;
        logic [15:0] status;
        is_res = $urandom_range(0, 2) != 0;
        t      = is_res ? cur_type : 14'($urandom);
        mand   = is_res ? 1'($urandom) : ($urandom_range(0, 4) == 0);
        if (is_res)
        begin
            case ($urandom_range(0, 7))
                0:       tlv_len = 16'd0;
                1:       tlv_len = 16'd1;
                2:       tlv_len = 16'($urandom_range(3, 6));
                default: tlv_len = 16'd2;
            endcase
        end
        else
            tlv_len = 16'($urandom_range(0, 5));
        case ($urandom_range(0, 4))
            0, 1:    status = cur_ok;
            2, 3:    status = cur_bad;
            default: status = 16'($urandom);
        endcase
        queue_byte({mand, 1'($urandom), t[13:8]});
        queue_byte(t[7:0]);
        queue_byte(tlv_len[15:8]);
        queue_byte(tlv_len[7:0]);
        for (int k = 0; k < int'(tlv_len); k++)
        begin
            if (is_res && k == 0)
                queue_byte(status[15:8]);
            else if (is_res && k == 1)
                queue_byte(status[7:0]);
            else
                queue_byte(8'($urandom));
        end
    endtask

    // Mostly well-formed messages with random content; the rest end inside
    // a value, in a header, with the last mark on its own, or cut short.
    task automatic build_random_message();
        int unsigned kind;
        int unsigned n_tlv;
        int unsigned extra;
        logic [15:0] huge_len;
        msg_words.delete();
        noise_on = $urandom_range(0, 3) == 0;
        kind     = $urandom_range(0, 11);
        n_tlv    = $urandom_range(0, 3);
        repeat (n_tlv) queue_tlv();
        case (kind)
            0:
            begin
                // declared length runs past the end of the message
                huge_len = 16'($urandom);
                queue_byte(8'($urandom));
                queue_byte(8'($urandom));
                queue_byte(huge_len[15:8]);
                queue_byte(huge_len[7:0]);
                repeat ($urandom_range(0, 4)) queue_byte(8'($urandom));
            end
            1: repeat ($urandom_range(1, 3)) queue_byte(8'($urandom));
            3:
            begin
                extra = $urandom_range(1, 3);
                while (extra > 0 && msg_words.size() > 0)
                begin
                    void'(msg_words.pop_back());
                    extra--;
                end
            end
            default: ;
        endcase
        seal_message(kind == 2);
    endtask

    initial
    begin
        int unsigned directed_words;
        int unsigned random_words;
        logic [15:0] same_code;

        rst_n             = 1'b0;
        calm              = 1'b0;
        long_hold         = 1'b0;
        noise_on          = 1'b0;
        sender_gaps       = 1'b0;
        payload_words     = 0;
        messages          = 0;
        settings_used     = 0;
        cur_type          = 14'd3;
        cur_ok            = 16'd1;
        cur_bad           = 16'd2;
        item_if.valid     <= 1'b0;
        item_if.data_byte <= 8'h00;
        item_if.has_byte  <= 1'b0;
        item_if.last      <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= REG_REQUEST_SUCCESS;
        cfg_if.data       <= 16'h0000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, reset register values ----
        // empty payload: outcome stays at continue
        payload_bytes = {};
        send_payload(1'b1);
        // Result TLV whose status is the success code while failure was requested
        payload_bytes = '{8'h00, 8'h03, 8'h00, 8'h02, 8'h00, 8'h01};
        send_payload(1'b0);
        // status is the failure code, reserved bit set, a skipped word inside
        payload_bytes = '{8'h40, 8'h03, 8'h00, 8'h02, 8'h00, 8'h02};
        msg_words.delete();
        foreach (payload_bytes[i])
            msg_words.push_back('{data: payload_bytes[i], has: 1'b1, fin: 1'b0});
        msg_words.insert(2, '{data: 8'hFF, has: 1'b0, fin: 1'b0});
        seal_message(1'b0);
        send_message();
        // optional TLV only, no Result TLV: sticky success must hold
        payload_bytes = '{8'h3F, 8'hFF, 8'h00, 8'h00};
        send_payload(1'b0);
        // unsupported mandatory TLV
        payload_bytes = '{8'h80, 8'h07, 8'h00, 8'h00};
        send_payload(1'b0);
        // Result TLV too short to hold a status, last mark on its own word
        payload_bytes = '{8'h00, 8'h03, 8'h00, 8'h01, 8'hFF};
        send_payload(1'b1);
        // message ends with one header byte
        payload_bytes = '{8'hFF};
        send_payload(1'b0);
        // declared length longer than the rest of the message
        payload_bytes = '{8'h00, 8'h03, 8'hFF, 8'hFF, 8'h00};
        send_payload(1'b0);
        directed_words = payload_words;

        // ---- random part, one register setting per phase ----
        for (int ph = 0; ph < int'(PHASES); ph++)
        begin
            same_code = 16'($urandom);
            case (ph)
                0: apply_setting(1'b0, 14'h0000, 16'h0000, 16'h0000);
                1: apply_setting(1'b1, 14'h3FFF, 16'hFFFF, 16'h0000);
                2: apply_setting(1'b1, 14'd3, 16'd1, 16'd2);
                4: apply_setting(1'($urandom), 14'($urandom), same_code, same_code);
                default: apply_setting(1'($urandom), 14'($urandom), 16'($urandom),
                                       16'($urandom));
            endcase
            calm = ph == int'(PHASES) - 1;

            if (ph == 2)
            begin
                // hold the result side off while empty messages keep coming,
                // so the parser fills up and stalls the byte channel
                long_hold = 1'b1;
                repeat (12)
                begin
                    msg_words.delete();
                    seal_message(1'b1);
                    send_message();
                end
            end

            random_words = payload_words - directed_words;
            while (random_words < (ph + 1) * ITEM_TARGET / PHASES)
            begin
                build_random_message();
                send_message();
                // now and then in phase 3, wait for all outcome words
                if (ph == 3 && $urandom_range(0, 5) == 0)
                    settle();
                random_words = payload_words - directed_words;
            end
        end

        settle();
        repeat (10) @(posedge clk);

        $display("Run covered %0d messages, %0d payload words, %0d register settings,",
                 messages, payload_words, settings_used);
        $display("with %0d outcome words compared against the prediction.", compared);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule : tb

// File: sim.f
rtl/eap_tlv_pkg.sv
rtl/eap_tlv_if.sv
rtl/eap_tlv_result_parser.sv
tb/tlv_outcome_monitor.sv
tb/tb.sv
